[rtl/plfu_pkg.sv]
// Package: shared types, constants and codes for the piecewise linear function unit.
`timescale 1ns / 1ps

package plfu_pkg;

  localparam int NUM_SEGMENTS_DEF = 10;

  localparam int MODE_W  = 2;
  localparam int IDX_W   = 4;
  localparam int VALUE_W = 32;
  localparam int X_W     = 16;
  localparam int BND_W   = 16;
  localparam int SLOPE_W = 16;
  localparam int ICPT_W  = 32;
  localparam int SEGO_W  = 4;

  localparam int DIFF_W  = X_W + 1;
  localparam int PROD_W  = DIFF_W + SLOPE_W;
  localparam int SCALE   = 7;
  localparam int ACC_W   = PROD_W + SCALE + 1;

  localparam logic [MODE_W-1:0] MODE_EVAL     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WR_BND   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WR_SLOPE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_WR_ICPT  = 2'd3;

  localparam logic [ICPT_W-1:0] RESULT_MAX = {1'b0, {(ICPT_W-1){1'b1}}};
  localparam logic [ICPT_W-1:0] RESULT_MIN = {1'b1, {(ICPT_W-1){1'b0}}};

  typedef struct packed {
    logic        [MODE_W-1:0]  mode;
    logic        [IDX_W-1:0]   entry_index;
    logic signed [VALUE_W-1:0] table_value;
    logic signed [X_W-1:0]     x_value;
  } in_item_t;

  typedef struct packed {
    logic signed [ICPT_W-1:0] result_value;
    logic        [SEGO_W-1:0] segment_used;
    logic                     saturated;
  } out_item_t;

  typedef struct packed {
    logic                     boundary_en;
    logic                     lower_en;
    logic                     slope_en;
    logic                     icpt_en;
    logic [IDX_W-1:0]         idx;
    logic [VALUE_W-1:0]       value;
  } wr_cmd_t;

endpackage

[rtl/piecewise_linear_function_unit.sv]
// Top level: input beat decode, table write commands, stage valids and stall chain.
`timescale 1ns / 1ps

// Five-stage pipeline that takes one beat per clock while item_stall is low
// and raises result_valid for an evaluate once it has passed the input
// register, boundary compare bank, coefficient memory read, 17x16 multiply,
// then scaled add with saturation into the output register. Write beats
// update the tables as they leave the input register and produce no result;
// an evaluate taken in the next cycle already sees the new entry. Stages that
// hold no beat absorb a downstream stall, so the unit keeps taking beats while
// the output waits.
module piecewise_linear_function_unit #(
  parameter int NUM_SEGMENTS = plfu_pkg::NUM_SEGMENTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  plfu_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output plfu_pkg::out_item_t result
);

  localparam int SEG_W = $clog2(NUM_SEGMENTS);

  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5;
  plfu_pkg::in_item_t s1_item;
  plfu_pkg::wr_cmd_t  wr;
  logic               fire1;
  logic               is_eval;
  logic               idx_le_n;
  logic               idx_lt_n;

  logic [SEG_W-1:0]                     seg2, seg3;
  logic signed [plfu_pkg::X_W-1:0]      x2, x3;
  logic signed [plfu_pkg::BND_W-1:0]    lower3;
  logic signed [plfu_pkg::SLOPE_W-1:0]  slope3;
  logic signed [plfu_pkg::ICPT_W-1:0]   icpt3;

  assign r5 = !v5 || !result_stall;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;

  assign item_stall   = !r1;
  assign result_valid = v5;

  assign fire1    = v1 && r2;
  assign is_eval  = s1_item.mode == plfu_pkg::MODE_EVAL;
  assign idx_le_n = 32'(s1_item.entry_index) <= 32'(NUM_SEGMENTS);
  assign idx_lt_n = 32'(s1_item.entry_index) < 32'(NUM_SEGMENTS);

  always_comb begin
    wr.boundary_en = fire1 && s1_item.mode == plfu_pkg::MODE_WR_BND && idx_le_n;
    wr.lower_en    = fire1 && s1_item.mode == plfu_pkg::MODE_WR_BND && idx_lt_n;
    wr.slope_en    = fire1 && s1_item.mode == plfu_pkg::MODE_WR_SLOPE && idx_lt_n;
    wr.icpt_en     = fire1 && s1_item.mode == plfu_pkg::MODE_WR_ICPT && idx_lt_n;
    wr.idx         = s1_item.entry_index;
    wr.value       = s1_item.table_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= item_valid;
      end
      if (r2) begin
        v2 <= v1 && is_eval;
      end
      if (r3) begin
        v3 <= v2;
      end
      if (r4) begin
        v4 <= v3;
      end
      if (r5) begin
        v5 <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      s1_item <= item;
    end
  end

  plfu_seg_select #(
    .NUM_SEGMENTS(NUM_SEGMENTS)
  ) u_seg_select (
    .clk   (clk),
    .wr    (wr),
    .load  (r2),
    .x_in  (s1_item.x_value),
    .seg   (seg2),
    .x_out (x2)
  );

  plfu_coef_mem #(
    .NUM_SEGMENTS(NUM_SEGMENTS)
  ) u_coef_mem (
    .clk     (clk),
    .wr      (wr),
    .load    (r3),
    .seg_in  (seg2),
    .x_in    (x2),
    .seg_out (seg3),
    .x_out   (x3),
    .lower   (lower3),
    .slope   (slope3),
    .icpt    (icpt3)
  );

  plfu_mac #(
    .NUM_SEGMENTS(NUM_SEGMENTS)
  ) u_mac (
    .clk      (clk),
    .load_mul (r4),
    .load_out (r5),
    .seg      (seg3),
    .x        (x3),
    .lower    (lower3),
    .slope    (slope3),
    .icpt     (icpt3),
    .result   (result)
  );

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !result_valid && !v1 && !v4)
    else $error("pipeline valid after reset");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.saturated |->
      result.result_value == plfu_pkg::RESULT_MAX ||
      result.result_value == plfu_pkg::RESULT_MIN)
    else $error("saturated result not at a range limit");

  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> 32'(result.segment_used) < 32'(NUM_SEGMENTS))
    else $error("segment index out of range");

  a_eval_advances: assert property (@(posedge clk) disable iff (rst)
    v1 && r2 && is_eval |=> v2)
    else $error("evaluate beat lost between stages");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    v1 && r2 && !is_eval && !v3 |=> !v3 || $past(v2))
    else $error("write beat produced a pipeline slot");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> v1 && v2 && v3 && v4 && v5)
    else $error("input stalled with a free stage");

endmodule

[rtl/plfu_seg_select.sv]
// Boundary registers and parallel compare bank that pick the segment for x.
`timescale 1ns / 1ps

module plfu_seg_select #(
  parameter int NUM_SEGMENTS = plfu_pkg::NUM_SEGMENTS_DEF
) (
  input  logic                                clk,
  input  plfu_pkg::wr_cmd_t                   wr,
  input  logic                                load,
  input  logic signed [plfu_pkg::X_W-1:0]     x_in,
  output logic [$clog2(NUM_SEGMENTS)-1:0]     seg,
  output logic signed [plfu_pkg::X_W-1:0]     x_out
);

  localparam int SEG_W  = $clog2(NUM_SEGMENTS);
  localparam int BIDX_W = $clog2(NUM_SEGMENTS + 1);

  logic signed [plfu_pkg::BND_W-1:0] bnd [NUM_SEGMENTS+1];
  logic [SEG_W-1:0]                  seg_next;

  always_ff @(posedge clk) begin
    if (wr.boundary_en) begin
      bnd[BIDX_W'(wr.idx)] <= wr.value[plfu_pkg::BND_W-1:0];
    end
  end

  always_comb begin
    seg_next = SEG_W'(NUM_SEGMENTS - 1);
    for (int j = NUM_SEGMENTS - 1; j >= 0; j--) begin
      if (x_in < bnd[j+1]) begin
        seg_next = SEG_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seg   <= seg_next;
      x_out <= x_in;
    end
  end

endmodule

[rtl/plfu_coef_mem.sv]
// Lower boundary, slope and intercept memories with registered reads.
`timescale 1ns / 1ps

module plfu_coef_mem #(
  parameter int NUM_SEGMENTS = plfu_pkg::NUM_SEGMENTS_DEF
) (
  input  logic                                 clk,
  input  plfu_pkg::wr_cmd_t                    wr,
  input  logic                                 load,
  input  logic [$clog2(NUM_SEGMENTS)-1:0]      seg_in,
  input  logic signed [plfu_pkg::X_W-1:0]      x_in,
  output logic [$clog2(NUM_SEGMENTS)-1:0]      seg_out,
  output logic signed [plfu_pkg::X_W-1:0]      x_out,
  output logic signed [plfu_pkg::BND_W-1:0]    lower,
  output logic signed [plfu_pkg::SLOPE_W-1:0]  slope,
  output logic signed [plfu_pkg::ICPT_W-1:0]   icpt
);

  localparam int SEG_W = $clog2(NUM_SEGMENTS);

  logic [plfu_pkg::BND_W-1:0]   lower_mem [NUM_SEGMENTS];
  logic [plfu_pkg::SLOPE_W-1:0] slope_mem [NUM_SEGMENTS];
  logic [plfu_pkg::ICPT_W-1:0]  icpt_mem  [NUM_SEGMENTS];

  always_ff @(posedge clk) begin
    if (wr.lower_en) begin
      lower_mem[SEG_W'(wr.idx)] <= wr.value[plfu_pkg::BND_W-1:0];
    end
    if (wr.slope_en) begin
      slope_mem[SEG_W'(wr.idx)] <= wr.value[plfu_pkg::SLOPE_W-1:0];
    end
    if (wr.icpt_en) begin
      icpt_mem[SEG_W'(wr.idx)] <= wr.value[plfu_pkg::ICPT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lower   <= lower_mem[seg_in];
      slope   <= slope_mem[seg_in];
      icpt    <= icpt_mem[seg_in];
      seg_out <= seg_in;
      x_out   <= x_in;
    end
  end

endmodule

[rtl/plfu_mac.sv]
// Multiply-add datapath: offset, product, scaled sum and saturation over two stages.
`timescale 1ns / 1ps

module plfu_mac #(
  parameter int NUM_SEGMENTS = plfu_pkg::NUM_SEGMENTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 load_mul,
  input  logic                                 load_out,
  input  logic [$clog2(NUM_SEGMENTS)-1:0]      seg,
  input  logic signed [plfu_pkg::X_W-1:0]      x,
  input  logic signed [plfu_pkg::BND_W-1:0]    lower,
  input  logic signed [plfu_pkg::SLOPE_W-1:0]  slope,
  input  logic signed [plfu_pkg::ICPT_W-1:0]   icpt,
  output plfu_pkg::out_item_t                  result
);

  localparam int SEG_W = $clog2(NUM_SEGMENTS);

  logic signed [plfu_pkg::DIFF_W-1:0] diff;
  logic signed [plfu_pkg::PROD_W-1:0] prod;
  logic signed [plfu_pkg::PROD_W-1:0] prod_q;
  logic signed [plfu_pkg::ICPT_W-1:0] icpt_q;
  logic [SEG_W-1:0]                   seg_q;
  logic signed [plfu_pkg::ACC_W-1:0]  acc;
  logic                               sat_hi;
  logic                               sat_lo;
  plfu_pkg::out_item_t                result_next;

  assign diff = plfu_pkg::DIFF_W'(x) - plfu_pkg::DIFF_W'(lower);
  assign prod = plfu_pkg::PROD_W'(diff) * plfu_pkg::PROD_W'(slope);

  always_ff @(posedge clk) begin
    if (load_mul) begin
      prod_q <= prod;
      icpt_q <= icpt;
      seg_q  <= seg;
    end
  end

  assign acc = (plfu_pkg::ACC_W'(prod_q) <<< plfu_pkg::SCALE) + plfu_pkg::ACC_W'(icpt_q);

  assign sat_hi = !acc[plfu_pkg::ACC_W-1] &&
                  (|acc[plfu_pkg::ACC_W-2:plfu_pkg::ICPT_W-1]);
  assign sat_lo = acc[plfu_pkg::ACC_W-1] &&
                  !(&acc[plfu_pkg::ACC_W-2:plfu_pkg::ICPT_W-1]);

  always_comb begin
    result_next.segment_used = plfu_pkg::SEGO_W'(seg_q);
    result_next.saturated    = sat_hi || sat_lo;
    if (sat_hi) begin
      result_next.result_value = plfu_pkg::RESULT_MAX;
    end else if (sat_lo) begin
      result_next.result_value = plfu_pkg::RESULT_MIN;
    end else begin
      result_next.result_value = acc[plfu_pkg::ICPT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result <= result_next;
    end
  end

endmodule

[dv/plfu_result_checker.sv]
// Checker: predicts piecewise linear results from accepted input beats and compares result beats.
`timescale 1ns / 1ps

module plfu_result_checker #(
  parameter int NUM_SEG = plfu_pkg::NUM_SEGMENTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_stall,
  input  plfu_pkg::in_item_t  item,
  input  logic                result_valid,
  input  logic                result_stall,
  input  plfu_pkg::out_item_t result,
  output int                  fail_count,
  output int                  pending
);

  localparam longint ACC_HI = 64'sd2147483647;
  localparam longint ACC_LO = -64'sd2147483648;

  logic signed [plfu_pkg::BND_W-1:0]   bnd_tab   [NUM_SEG+1];
  logic signed [plfu_pkg::SLOPE_W-1:0] slope_tab [NUM_SEG];
  logic signed [plfu_pkg::ICPT_W-1:0]  icpt_tab  [NUM_SEG];
  plfu_pkg::out_item_t                 expected_results [$];
  int                                  fails   = 0;
  int                                  waiting = 0;

  assign fail_count = fails;
  assign pending    = waiting;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fails++;
  endtask

  function automatic plfu_pkg::out_item_t interpolate(
    input logic signed [plfu_pkg::X_W-1:0] x);
    plfu_pkg::out_item_t r;
    int                  seg;
    longint              acc;
    seg = NUM_SEG - 1;
    // scan downward so the lowest matching segment wins
    for (int j = NUM_SEG - 1; j >= 0; j--)
      if (x < bnd_tab[j+1]) seg = j;
    acc = (longint'(x) - longint'(bnd_tab[seg])) * longint'(slope_tab[seg]) * 128
          + longint'(icpt_tab[seg]);
    r.saturated = 1'b0;
    if (acc > ACC_HI) begin
      r.result_value = plfu_pkg::RESULT_MAX;
      r.saturated    = 1'b1;
    end else if (acc < ACC_LO) begin
      r.result_value = plfu_pkg::RESULT_MIN;
      r.saturated    = 1'b1;
    end else begin
      r.result_value = acc[plfu_pkg::ICPT_W-1:0];
    end
    r.segment_used = seg[plfu_pkg::SEGO_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch_beats
    plfu_pkg::out_item_t exp_r;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        case (item.mode)
          plfu_pkg::MODE_EVAL: begin
            expected_results.insert(expected_results.size(), interpolate(item.x_value));
          end
          plfu_pkg::MODE_WR_BND: begin
            if (item.entry_index <= NUM_SEG)
              bnd_tab[item.entry_index] = item.table_value[plfu_pkg::BND_W-1:0];
          end
          plfu_pkg::MODE_WR_SLOPE: begin
            if (item.entry_index < NUM_SEG)
              slope_tab[item.entry_index] = item.table_value[plfu_pkg::SLOPE_W-1:0];
          end
          plfu_pkg::MODE_WR_ICPT: begin
            if (item.entry_index < NUM_SEG)
              icpt_tab[item.entry_index] = item.table_value[plfu_pkg::ICPT_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with no evaluate outstanding");
        end else begin
          exp_r = expected_results.pop_front();
          if (result.result_value !== exp_r.result_value)
            report_mismatch($sformatf("result_value got %h expected %h",
                                      result.result_value, exp_r.result_value));
          if (result.segment_used !== exp_r.segment_used)
            report_mismatch($sformatf("segment_used got %0d expected %0d",
                                      result.segment_used, exp_r.segment_used));
          if (result.saturated !== exp_r.saturated)
            report_mismatch($sformatf("saturated got %b expected %b",
                                      result.saturated, exp_r.saturated));
        end
      end
      waiting = expected_results.size();
    end
  end

endmodule

[dv/testbench.sv]
// Testbench top: drives table writes and evaluate beats into the unit and gives the verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int NSEG         = plfu_pkg::NUM_SEGMENTS_DEF;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 700;
  localparam int DRAIN_CYCLES = 20;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                item_valid   = 1'b0;
  logic                item_stall;
  plfu_pkg::in_item_t  item         = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  plfu_pkg::out_item_t result;

  int   fail_count;
  int   pending;
  int   cycles         = 0;
  int   recv_stall_pct = 0;
  int   send_idle_pct  = 0;
  int   sent           = 0;
  logic hold_req       = 1'b0;
  logic hold_taken     = 1'b0;
  int   hold_left      = 0;

  logic signed [plfu_pkg::BND_W-1:0] bnd_shadow [NSEG+1];

  piecewise_linear_function_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  plfu_result_checker result_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // hold off once for a long stretch on request, otherwise stall at random
  always @(posedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      result_stall <= 1'b1;
      hold_left    <= LONG_HOLD;
      hold_taken   <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic logic [15:0] rand16();
    logic [31:0] r;
    r = $urandom();
    return r[15:0];
  endfunction

  function automatic plfu_pkg::in_item_t write_beat(
    input logic [plfu_pkg::MODE_W-1:0] m, input int idx,
    input logic [plfu_pkg::VALUE_W-1:0] v);
    plfu_pkg::in_item_t b;
    b.mode        = m;
    b.entry_index = idx[plfu_pkg::IDX_W-1:0];
    b.table_value = v;
    b.x_value     = rand16();
    return b;
  endfunction

  function automatic plfu_pkg::in_item_t eval_beat(
    input logic signed [plfu_pkg::X_W-1:0] x);
    plfu_pkg::in_item_t b;
    logic [31:0]        r;
    r             = $urandom();
    b.mode        = plfu_pkg::MODE_EVAL;
    b.entry_index = r[plfu_pkg::IDX_W-1:0];
    b.table_value = $urandom();
    b.x_value     = x;
    return b;
  endfunction

  task automatic send_beat(input plfu_pkg::in_item_t b);
    logic stalled;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= b;
    if (b.mode == plfu_pkg::MODE_WR_BND && b.entry_index <= NSEG)
      bnd_shadow[b.entry_index] = b.table_value[plfu_pkg::BND_W-1:0];
    do begin
      @(negedge clk);
      stalled = item_stall;
      @(posedge clk);
    end while (stalled);
    sent++;
  endtask

  task automatic wait_for_results();
    item_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic load_sorted_boundaries();
    int level;
    int step_max;
    step_max = ($urandom_range(3) == 0) ? 40 : 6500;
    level    = -32768 + int'($urandom_range(3000));
    for (int k = 0; k <= NSEG; k++) begin
      if (level > 32767) level = 32767;
      send_beat(write_beat(plfu_pkg::MODE_WR_BND, k, {rand16(), 16'(level)}));
      level += int'($urandom_range(step_max, 1));
    end
  endtask

  task automatic load_segment(input int k);
    logic [15:0] slope_v;
    logic [31:0] icpt_v;
    if ($urandom_range(1) == 1) begin
      slope_v = rand16();
      icpt_v  = $urandom();
    end else begin
      slope_v = 16'(int'($urandom_range(512)) - 256);
      icpt_v  = 32'(int'($urandom_range(1 << 25)) - (1 << 24));
    end
    send_beat(write_beat(plfu_pkg::MODE_WR_SLOPE, k, {rand16(), slope_v}));
    send_beat(write_beat(plfu_pkg::MODE_WR_ICPT, k, icpt_v));
  endtask

  task automatic random_eval();
    logic signed [plfu_pkg::X_W-1:0] x;
    case ($urandom_range(9))
      0: begin
        x = ($urandom_range(1) == 1) ? 16'sh7fff : 16'sh8000;
      end
      1, 2, 3, 4: begin
        x = bnd_shadow[$urandom_range(NSEG)] + 16'($urandom_range(6)) - 16'd3;
      end
      default: begin
        x = rand16();
      end
    endcase
    send_beat(eval_beat(x));
  endtask

  task automatic random_action();
    int                          pick;
    logic [plfu_pkg::MODE_W-1:0] m;
    pick = $urandom_range(99);
    if (pick < 3) begin
      load_sorted_boundaries();
    end else if (pick < 13) begin
      load_segment($urandom_range(NSEG - 1));
    end else if (pick < 18) begin
      case ($urandom_range(2))
        0:       m = plfu_pkg::MODE_WR_BND;
        1:       m = plfu_pkg::MODE_WR_SLOPE;
        default: m = plfu_pkg::MODE_WR_ICPT;
      endcase
      send_beat(write_beat(m, $urandom_range(15), $urandom()));
    end else begin
      random_eval();
    end
  endtask

  initial begin : stimulus
    int          b_pts [NSEG+1];
    int          x_pts [8];
    logic [15:0] slope_v;
    logic [31:0] icpt_v;
    int          base;

    b_pts = '{-32768, -26000, -19000, -12000, -5000, 0, 5000, 12000, 19000, 26000, 32767};
    x_pts = '{-32768, -26001, -1, 0, 11999, 12000, 32766, 32767};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k <= NSEG; k++)
      send_beat(write_beat(plfu_pkg::MODE_WR_BND, k, {rand16(), 16'(b_pts[k])}));
    for (int k = 0; k < NSEG; k++) begin
      slope_v = (k == 0) ? 16'h8000 : (k == NSEG - 1) ? 16'h7fff : 16'(k * 97 - 400);
      icpt_v  = (k == 0) ? 32'h8000_0000 : (k == NSEG - 1) ? 32'h7fff_ffff : 32'(k << 21);
      send_beat(write_beat(plfu_pkg::MODE_WR_SLOPE, k, {rand16(), slope_v}));
      send_beat(write_beat(plfu_pkg::MODE_WR_ICPT, k, icpt_v));
    end
    send_beat(write_beat(plfu_pkg::MODE_WR_BND, NSEG + 1, $urandom()));
    send_beat(write_beat(plfu_pkg::MODE_WR_SLOPE, NSEG, $urandom()));
    send_beat(write_beat(plfu_pkg::MODE_WR_ICPT, 15, $urandom()));
    foreach (x_pts[i])
      send_beat(eval_beat(16'(x_pts[i])));
    // out-of-order boundary: first match still decides
    send_beat(write_beat(plfu_pkg::MODE_WR_BND, 3, {rand16(), 16'sd30000}));
    send_beat(eval_beat(16'(-12000)));
    send_beat(write_beat(plfu_pkg::MODE_WR_BND, 3, {rand16(), 16'(b_pts[3])}));
    wait_for_results();

    base          = sent;
    send_idle_pct = 12;
    recv_stall_pct <= 75;
    while (sent < base + RANDOM_ITEMS / 3) random_action();
    wait_for_results();

    send_idle_pct = 75;
    recv_stall_pct <= 12;
    while (sent < base + 2 * RANDOM_ITEMS / 3) random_action();
    wait_for_results();

    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_req <= 1'b1;
    repeat (40) random_eval();
    while (sent < base + RANDOM_ITEMS) random_action();
    wait_for_results();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
